>>> rtl/core/thc_pkg.sv
// Shared types and constants for the temperature and humidity compensation pipeline.
package thc_pkg;

   // number of register stages from input to result
   localparam int NUM_STAGES = 15;

   // configuration register indexes
   localparam logic [2:0] REG_TEMP_COEF_1  = 3'd0;
   localparam logic [2:0] REG_TEMP_COEF_2  = 3'd1;
   localparam logic [2:0] REG_TEMP_COEF_3  = 3'd2;
   localparam logic [2:0] REG_HUM_COEF_1   = 3'd3;
   localparam logic [2:0] REG_HUM_COEF_2   = 3'd4;
   localparam logic [2:0] REG_HUM_COEF_3   = 3'd5;
   localparam logic [2:0] REG_HUM_COEF_4_5 = 3'd6;
   localparam logic [2:0] REG_HUM_COEF_6   = 3'd7;

   // arithmetic constants of the compensation formulae
   localparam logic [31:0] TEMP_OFFSET   = 32'd76800;
   localparam logic [31:0] HUM_MAX       = 32'd419430400;
   localparam logic [31:0] HUM_BIAS      = 32'd2097152;
   localparam logic [31:0] HUM_ROUND_15  = 32'd16384;
   localparam logic [31:0] HUM_SLOPE_OFS = 32'd32768;
   localparam logic [31:0] HUM_ROUND_14  = 32'd8192;
   localparam logic [31:0] CENTI_ROUND   = 32'd128;
   localparam logic [16:0] HUM_Q10_MAX   = 17'd102400;

   // per-stage advance enables and valid bits
   typedef struct packed {
      logic [NUM_STAGES:1] en;
      logic [NUM_STAGES:1] vld;
   } thc_pipe_ctl_type;

endpackage

>>> rtl/core/thc_pipe_ctrl.sv
// Valid and advance control for the compensation pipeline.
module thc_pipe_ctrl
   import thc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             out_stall,
   output logic             in_stall,
   output thc_pipe_ctl_type ctl
);

   logic [NUM_STAGES:1] vld_ff;
   logic [NUM_STAGES:1] vld_in;
   logic [NUM_STAGES:1] en;

   // advance a stage when it is empty or the stage after it advances
   always_comb begin
      en[NUM_STAGES] = !vld_ff[NUM_STAGES] || !out_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k + 1];
      end
   end

   // move valid bits along with the data
   always_comb begin
      vld_in = vld_ff;
      if (en[1]) begin
         vld_in[1] = in_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_stall = !en[1];
   assign ctl.en   = en;
   assign ctl.vld  = vld_ff;

endmodule

>>> rtl/core/temp_humidity_compensation.sv
// Top level of the temperature and humidity compensation pipeline.
//
//   channel   direction  handshake          payload
//   req_      in         valid / stall      raw_temperature[19:0], raw_humidity[15:0]
//   rsp_      out        valid / stall      fine_temperature[31:0], temperature_centi[23:0],
//                                           humidity_q10[16:0]
//   csr_      in         valid / ready      index[2:0], wdata[23:0]
//
// One reading enters per cycle while req_stall is low; 15 register stages, the first loaded
// at the edge that takes the reading and the last offering its result, a depth set by the
// chain of dependent multiplications in the humidity formula.
// Synchronous reset empties the pipeline and loads the coefficients with their reset values.
// A stalled result holds its stage; earlier stages keep advancing into empty slots, so the
// pipeline takes readings until all 15 stages are full.
// Coefficient writes are always accepted and feed several stages at once, so the user must make
// them only while no reading is in flight; the block itself does not enforce this.
module temp_humidity_compensation
   import thc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [19:0]        req_raw_temperature,
   input  logic [15:0]        req_raw_humidity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_fine_temperature,
   output logic signed [23:0] rsp_temperature_centi,
   output logic [16:0]        rsp_humidity_q10,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   thc_pipe_ctl_type ctl;

   // coefficient registers
   logic [15:0] temp_coef_1_ff;
   logic [15:0] temp_coef_2_ff;
   logic [15:0] temp_coef_3_ff;
   logic [7:0]  hum_coef_1_ff;
   logic [15:0] hum_coef_2_ff;
   logic [7:0]  hum_coef_3_ff;
   logic [23:0] hum_coef_4_5_ff;
   logic [7:0]  hum_coef_6_ff;

   // coefficients widened to 32 bits
   logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;

   // stage registers and their next values
   logic [31:0] s1_da_ff, s1_da_in, s1_d_ff, s1_d_in;
   logic [31:0] s2_pa_ff, s2_pa_in, s2_dd_ff, s2_dd_in;
   logic [31:0] s3_at_ff, s3_at_in, s3_e_ff, s3_e_in;
   logic [31:0] s4_fine_in;
   logic [31:0] s5_v_ff, s5_v_in;
   logic [31:0] s6_m5_ff, s6_m5_in, s6_m6_ff, s6_m6_in, s6_m3_ff, s6_m3_in;
   logic [31:0] s6_cp_ff, s6_cp_in;
   logic [31:0] s7_ah_in, s7_b1a_ff, s7_b1a_in, s7_b1b_ff, s7_b1b_in;
   logic [23:0] s7_centi_in;
   logic [31:0] s8_ah_in, s8_bm_ff, s8_bm_in;
   logic [31:0] s9_b2_ff, s9_b2_in;
   logic [31:0] s10_bh_ff, s10_bh_in;
   logic [31:0] s11_b3_ff, s11_b3_in;
   logic [31:0] s12_vv_in;
   logic [31:0] s13_qq_ff, s13_qq_in;
   logic [31:0] s14_r_ff, s14_r_in;
   logic [31:0] s15_w;
   logic [16:0] s15_hum_in;
   logic [16:0] hum_ff;

   // carried values, one register per stage
   logic [15:0] hraw_ff  [1:6];
   logic [31:0] fine_ff  [4:NUM_STAGES];
   logic [23:0] centi_ff [7:NUM_STAGES];
   logic [31:0] ah_ff    [7:11];
   logic [31:0] vv_ff    [12:14];

   thc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_stall (rsp_stall),
      .in_stall  (req_stall),
      .ctl       (ctl)
   );

   // take coefficient words
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coef_1_ff  <= '0;
         temp_coef_2_ff  <= '0;
         temp_coef_3_ff  <= '0;
         hum_coef_1_ff   <= '0;
         hum_coef_2_ff   <= '0;
         hum_coef_3_ff   <= 8'd1;
         hum_coef_4_5_ff <= '0;
         hum_coef_6_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TEMP_COEF_1:  temp_coef_1_ff  <= csr_wdata[15:0];
            REG_TEMP_COEF_2:  temp_coef_2_ff  <= csr_wdata[15:0];
            REG_TEMP_COEF_3:  temp_coef_3_ff  <= csr_wdata[15:0];
            REG_HUM_COEF_1:   hum_coef_1_ff   <= csr_wdata[7:0];
            REG_HUM_COEF_2:   hum_coef_2_ff   <= csr_wdata[15:0];
            REG_HUM_COEF_3:   hum_coef_3_ff   <= csr_wdata[7:0];
            REG_HUM_COEF_4_5: hum_coef_4_5_ff <= csr_wdata;
            REG_HUM_COEF_6:   hum_coef_6_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // widen coefficients, sign-extending the signed ones
   assign t1 = {16'd0, temp_coef_1_ff};
   assign t2 = {{16{temp_coef_2_ff[15]}}, temp_coef_2_ff};
   assign t3 = {{16{temp_coef_3_ff[15]}}, temp_coef_3_ff};
   assign h1 = {24'd0, hum_coef_1_ff};
   assign h2 = {{16{hum_coef_2_ff[15]}}, hum_coef_2_ff};
   assign h3 = {24'd0, hum_coef_3_ff};
   assign h4 = {{20{hum_coef_4_5_ff[11]}}, hum_coef_4_5_ff[11:0]};
   assign h5 = {{20{hum_coef_4_5_ff[23]}}, hum_coef_4_5_ff[23:12]};
   assign h6 = {{24{hum_coef_6_ff[7]}}, hum_coef_6_ff};

   // next values of every stage; all arithmetic wraps at 32 bits
   always_comb begin
      // temperature terms
      s1_da_in    = {15'd0, req_raw_temperature[19:3]} - {t1[30:0], 1'b0};
      s1_d_in     = {16'd0, req_raw_temperature[19:4]} - t1;
      s2_pa_in    = s1_da_ff * t2;
      s2_dd_in    = s1_d_ff * s1_d_ff;
      s3_at_in    = 32'($signed(s2_pa_ff) >>> 11);
      s3_e_in     = 32'($signed(s2_dd_ff) >>> 12) * t3;
      s4_fine_in  = s3_at_ff + 32'($signed(s3_e_ff) >>> 14);
      s5_v_in     = fine_ff[4] - TEMP_OFFSET;
      // humidity products on the offset temperature, centi scaling
      s6_m5_in    = h5 * s5_v_ff;
      s6_m6_in    = s5_v_ff * h6;
      s6_m3_in    = s5_v_ff * h3;
      s6_cp_in    = fine_ff[5] + {fine_ff[5][29:0], 2'b00} + CENTI_ROUND;
      s7_ah_in    = {2'd0, hraw_ff[6], 14'd0} - {h4[11:0], 20'd0} - s6_m5_ff;
      s7_b1a_in   = 32'($signed(s6_m6_ff) >>> 10);
      s7_b1b_in   = 32'($signed(s6_m3_ff) >>> 11) + HUM_SLOPE_OFS;
      s7_centi_in = s6_cp_ff[31:8];
      s8_ah_in    = 32'($signed(ah_ff[7] + HUM_ROUND_15) >>> 15);
      s8_bm_in    = s7_b1a_ff * s7_b1b_ff;
      s9_b2_in    = 32'($signed(s8_bm_ff) >>> 10) + HUM_BIAS;
      s10_bh_in   = s9_b2_ff * h2;
      s11_b3_in   = 32'($signed(s10_bh_ff + HUM_ROUND_14) >>> 14);
      s12_vv_in   = ah_ff[11] * s11_b3_ff;
      s13_qq_in   = 32'($signed(vv_ff[12]) >>> 15) * 32'($signed(vv_ff[12]) >>> 15);
      s14_r_in    = 32'($signed(s13_qq_ff) >>> 7) * h1;
      // quadratic correction, clamp, scale to Q7.10
      s15_w       = vv_ff[14] - 32'($signed(s14_r_ff) >>> 4);
      if (s15_w[31]) begin
         s15_hum_in = '0;
      end else if (s15_w > HUM_MAX) begin
         s15_hum_in = HUM_MAX[28:12];
      end else begin
         s15_hum_in = s15_w[28:12];
      end
   end

   // load each stage when it advances
   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         s1_da_ff   <= s1_da_in;
         s1_d_ff    <= s1_d_in;
         hraw_ff[1] <= req_raw_humidity;
      end
      if (ctl.en[2]) begin
         s2_pa_ff <= s2_pa_in;
         s2_dd_ff <= s2_dd_in;
      end
      if (ctl.en[3]) begin
         s3_at_ff <= s3_at_in;
         s3_e_ff  <= s3_e_in;
      end
      if (ctl.en[4]) begin
         fine_ff[4] <= s4_fine_in;
      end
      if (ctl.en[5]) begin
         s5_v_ff <= s5_v_in;
      end
      if (ctl.en[6]) begin
         s6_m5_ff <= s6_m5_in;
         s6_m6_ff <= s6_m6_in;
         s6_m3_ff <= s6_m3_in;
         s6_cp_ff <= s6_cp_in;
      end
      if (ctl.en[7]) begin
         ah_ff[7]    <= s7_ah_in;
         s7_b1a_ff   <= s7_b1a_in;
         s7_b1b_ff   <= s7_b1b_in;
         centi_ff[7] <= s7_centi_in;
      end
      if (ctl.en[8]) begin
         ah_ff[8] <= s8_ah_in;
         s8_bm_ff <= s8_bm_in;
      end
      if (ctl.en[9]) begin
         s9_b2_ff <= s9_b2_in;
      end
      if (ctl.en[10]) begin
         s10_bh_ff <= s10_bh_in;
      end
      if (ctl.en[11]) begin
         s11_b3_ff <= s11_b3_in;
      end
      if (ctl.en[12]) begin
         vv_ff[12] <= s12_vv_in;
      end
      if (ctl.en[13]) begin
         s13_qq_ff <= s13_qq_in;
      end
      if (ctl.en[14]) begin
         s14_r_ff <= s14_r_in;
      end
      if (ctl.en[NUM_STAGES]) begin
         hum_ff <= s15_hum_in;
      end
   end

   // carry values that several stages need further down
   always_ff @(posedge clock) begin
      for (int k = 2; k <= 6; k++) begin
         if (ctl.en[k]) begin
            hraw_ff[k] <= hraw_ff[k - 1];
         end
      end
      for (int k = 5; k <= NUM_STAGES; k++) begin
         if (ctl.en[k]) begin
            fine_ff[k] <= fine_ff[k - 1];
         end
      end
      for (int k = 8; k <= NUM_STAGES; k++) begin
         if (ctl.en[k]) begin
            centi_ff[k] <= centi_ff[k - 1];
         end
      end
      for (int k = 9; k <= 11; k++) begin
         if (ctl.en[k]) begin
            ah_ff[k] <= ah_ff[k - 1];
         end
      end
      for (int k = 13; k <= 14; k++) begin
         if (ctl.en[k]) begin
            vv_ff[k] <= vv_ff[k - 1];
         end
      end
   end

   // drive the result word from the last stage
   assign rsp_valid             = ctl.vld[NUM_STAGES];
   assign rsp_fine_temperature  = $signed(fine_ff[NUM_STAGES]);
   assign rsp_temperature_centi = $signed(centi_ff[NUM_STAGES]);
   assign rsp_humidity_q10      = hum_ff;

endmodule

>>> rtl/core/thc_checker.sv
// Port-level checks for the compensation pipeline, bound to the top level.
module thc_checker
   import thc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [19:0]        req_raw_temperature,
   input logic [15:0]        req_raw_humidity,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_fine_temperature,
   input logic signed [23:0] rsp_temperature_centi,
   input logic [16:0]        rsp_humidity_q10,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [2:0]         csr_index,
   input logic [23:0]        csr_wdata
);

   logic [31:0] centi_full;

   // centi scaling of the fine temperature shown on the result word
   assign centi_full = 32'(rsp_fine_temperature) * 32'd5 + CENTI_ROUND;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fine_temperature)
         && $stable(rsp_temperature_centi) && $stable(rsp_humidity_q10))
      else $error("stalled result word changed");

   // no result straight out of reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid just after reset");

   // humidity never exceeds full scale
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_q10 <= HUM_Q10_MAX)
      else $error("humidity above full scale");

   // centi temperature matches the fine temperature of the same word
   a_centi_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 24'(rsp_temperature_centi) == centi_full[31:8])
      else $error("centi temperature does not match fine temperature");

endmodule

bind temp_humidity_compensation thc_checker u_thc_checker (.*);
